// ===== rtl/lut_piecewise_linear_interp_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear lookup block
// Concurrent checks in two shapes: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef LUT_PIECEWISE_LINEAR_INTERP_MACROS_SVH
`define LUT_PIECEWISE_LINEAR_INTERP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LPLI_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LPLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lpli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpli_pkg
// Shared types, widths and codes of the piecewise linear lookup block.
// ----------------------------------------------------------------------------
package lpli_pkg;

  // Table depth default
  localparam int unsigned DEF_MAX_POINTS = 16;

  // Field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_IN_W   = 4;
  localparam int unsigned PC_W       = 5;
  localparam int unsigned EXT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Input tdata layout, lowest bit up
  localparam int unsigned F_IDX_LSB  = 0;
  localparam int unsigned F_EX_LSB   = F_IDX_LSB + IDX_IN_W;
  localparam int unsigned F_EY_LSB   = F_EX_LSB + DATA_W;
  localparam int unsigned F_QX_LSB   = F_EY_LSB + DATA_W;
  localparam int unsigned S_TDATA_W  = ((F_QX_LSB + DATA_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = DATA_W;

  // Divider geometry: 64-bit product, 40 quotient bits kept
  localparam int unsigned NUM_W      = 2 * DATA_W;
  localparam int unsigned QUO_W      = 40;
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W + 1);
  localparam int unsigned SUM_W      = QUO_W + 2;
  localparam int unsigned DIFF_W     = DATA_W + 1;

  // Saturation limits
  localparam logic [DATA_W-1:0] Y_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Y_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Item kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRAP_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 2'd2;

  // Out-of-range and in-range modes
  localparam logic [EXT_W-1:0] EXTRAP_CLAMP  = 2'd0;
  localparam logic [EXT_W-1:0] EXTRAP_LINEAR = 2'd1;
  localparam logic             INTERP_LINEAR = 1'b0;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_EXT_LO,
    S_EXT_HI,
    S_SCAN,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_DONE
  } lpli_state_e;

  // One table entry
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } entry_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [PC_W-1:0]  point_count;
    logic [EXT_W-1:0] extrap_mode;
    logic             interp_mode;
  } cfg_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             big;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/lut_piecewise_linear_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_piecewise_linear_interp
// Breakpoint table with linear interpolation and selectable extrapolation.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid_i/s_axis_tready_o tdata: index, x, y, query
//                                                       tuser: action
//  m_axis    out        m_axis_tvalid_o/m_axis_tready_i tdata: y_value
//                                                       tuser: saturated
//  cfg       in         cfg_we_i (no wait)             cfg_index_i, cfg_wdata_i
//
//  A lookup result follows its transfer through the search and the divide:
//  the search reads one entry a cycle through the
//  table's single registered read port, and the divider resolves one quotient
//  bit a cycle over 40 steps (skipped when the quotient overflows).
//  Reset clears the configuration registers and control; the table is not cleared.
//  A finished result waits in the output register; the next item may transfer
//  meanwhile, and a later lookup holds its result until that register frees.
// ----------------------------------------------------------------------------
module lut_piecewise_linear_interp #(
  parameter int unsigned MAX_POINTS = lpli_pkg::DEF_MAX_POINTS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Items: tdata = entry_index[3:0], entry_x[35:4], entry_y[67:36],
  //        query_x[99:68], zero padding[103:100]
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [lpli_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // tuser = action[0]
  input  logic                               s_axis_tuser_i,
  // Results: tdata = y_value[31:0]
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [lpli_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // tuser = saturated[0]
  output logic                               m_axis_tuser_o,
  // Register writes
  input  logic                               cfg_we_i,
  input  logic [lpli_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lpli_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_POINTS);

  logic [lpli_pkg::PC_W-1:0]  point_count_q;
  logic [lpli_pkg::EXT_W-1:0] extrap_mode_q;
  logic                       interp_mode_q;

  lpli_pkg::cfg_t     cfg;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  lpli_pkg::entry_t   mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  lpli_pkg::entry_t   mem_rdata;
  lpli_pkg::div_req_t div_req;
  lpli_pkg::div_rsp_t div_rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      extrap_mode_q <= '0;
      interp_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lpli_pkg::REG_POINT_COUNT: begin
          point_count_q <= cfg_wdata_i[lpli_pkg::PC_W-1:0];
        end
        lpli_pkg::REG_EXTRAP_MODE: begin
          extrap_mode_q <= cfg_wdata_i[lpli_pkg::EXT_W-1:0];
        end
        lpli_pkg::REG_INTERP_MODE: begin
          interp_mode_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.point_count = point_count_q;
  assign cfg.extrap_mode = extrap_mode_q;
  assign cfg.interp_mode = interp_mode_q;

  lpli_table_mem #(
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lpli_div_unit u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lpli_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp)
  );

endmodule

// ===== rtl/lpli_table_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpli_table_mem
// Breakpoint table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpli_table_mem #(
  parameter int unsigned DEPTH = lpli_pkg::DEF_MAX_POINTS,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  lpli_pkg::entry_t      wdata_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output lpli_pkg::entry_t      rdata_o
);

  lpli_pkg::entry_t mem_q [DEPTH];
  lpli_pkg::entry_t rdata_q;

  // Store one entry per write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lpli_div_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpli_div_unit
// Restoring divider, one quotient bit a cycle, with early overflow detect.
// ----------------------------------------------------------------------------
`include "lut_piecewise_linear_interp_macros.svh"

module lpli_div_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpli_pkg::div_req_t req_i,
  output lpli_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW = lpli_pkg::DATA_W;
  localparam int unsigned QW = lpli_pkg::QUO_W;
  localparam int unsigned CW = lpli_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic          big_q, big_d;

  logic          done;
  logic [DW-1:0] num_top;
  logic [DW:0]   trial;
  logic [DW:0]   trial_diff;
  logic          trial_ge;

  assign done    = busy_q && (cnt_q == '0);
  assign num_top = DW'(req_i.num[lpli_pkg::NUM_W-1:QW]);

  // Shift one dividend bit into the remainder and try the subtract
  assign trial      = {rem_q, quo_q[QW-1]};
  assign trial_diff = trial - {1'b0, den_q};
  assign trial_ge   = trial >= {1'b0, den_q};

  // Load on start, step while counting, release on done
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    big_d  = big_q;
    if (req_i.start) begin
      big_d  = num_top >= req_i.den;
      rem_d  = num_top;
      quo_d  = req_i.num[QW-1:0];
      den_d  = req_i.den;
      busy_d = 1'b1;
      cnt_d  = (num_top >= req_i.den) ? '0 : CW'(QW);
    end else if (busy_q && (cnt_q != '0)) begin
      rem_d = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[QW-2:0], trial_ge};
      cnt_d = cnt_q - CW'(1);
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    big_q <= big_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done;
  assign rsp_o.big  = big_q;
  assign rsp_o.quo  = quo_q;

  `LPLI_ASSERT_NEXT(a_div_start_busy, clk_i, rst_ni, req_i.start, busy_q, "divider idle after start")
  `LPLI_ASSERT_NEXT(a_div_count_down, clk_i, rst_ni, busy_q && (cnt_q != '0) && !req_i.start, cnt_q == ($past(cnt_q) - CW'(1)), "divider step count skipped")

endmodule

// ===== rtl/lpli_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpli_ctrl
// Sequencer: handshakes, segment search, segment setup, result shaping.
// ----------------------------------------------------------------------------
`include "lut_piecewise_linear_interp_macros.svh"

module lpli_ctrl #(
  parameter int unsigned MAX_POINTS = lpli_pkg::DEF_MAX_POINTS,
  localparam int unsigned ADDR_W = $clog2(MAX_POINTS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lpli_pkg::cfg_t                   cfg_i,
  // Item stream in
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [lpli_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,
  // Result stream out
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [lpli_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tuser_o,
  // Table port
  output logic                             mem_we_o,
  output logic [ADDR_W-1:0]                mem_waddr_o,
  output lpli_pkg::entry_t                 mem_wdata_o,
  output logic [ADDR_W-1:0]                mem_raddr_o,
  input  lpli_pkg::entry_t                 mem_rdata_i,
  // Divider port
  output lpli_pkg::div_req_t               div_req_o,
  input  lpli_pkg::div_rsp_t               div_rsp_i
);

  localparam int unsigned DW    = lpli_pkg::DATA_W;
  localparam int unsigned XW    = lpli_pkg::DIFF_W;
  localparam int unsigned SW    = lpli_pkg::SUM_W;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  lpli_pkg::lpli_state_e state_q, state_d;

  logic [DW-1:0]          qx_q, qx_d;
  lpli_pkg::entry_t       lo_q, lo_d;
  logic [ADDR_W-1:0]      idx_q, idx_d;
  logic [XW-1:0]          dx_q, dx_d;
  logic [XW-1:0]          dy_q, dy_d;
  logic [XW-1:0]          t_q, t_d;
  logic [DW-1:0]          y0_q, y0_d;
  logic [lpli_pkg::NUM_W-1:0] prod_q, prod_d;
  logic [DW-1:0]          dmag_q, dmag_d;
  logic                   neg_q, neg_d;
  logic [DW-1:0]          res_y_q, res_y_d;
  logic                   res_sat_q, res_sat_d;
  logic                   out_valid_q, out_valid_d;
  logic [DW-1:0]          out_y_q, out_y_d;
  logic                   out_sat_q, out_sat_d;

  logic [CNT_W-1:0]       n_eff;
  logic                   few_points;
  logic [ADDR_W-1:0]      last_idx;
  logic                   in_range;
  logic                   seg_load;
  lpli_pkg::entry_t       seg_a, seg_b;
  logic [XW-1:0]          seg_dx, seg_dy, seg_t;
  logic [XW-1:0]          dx_abs, dy_abs, t_abs;
  logic [SW-1:0]          y0_ext, q_ext, sum;
  logic                   sum_ovf;
  logic                   q_below, q_above, q_le;

  // Points in use, capped at the table depth
  assign n_eff      = (32'(cfg_i.point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                             : CNT_W'(cfg_i.point_count);
  assign few_points = n_eff < CNT_W'(2);
  assign last_idx   = ADDR_W'(n_eff - CNT_W'(1));

  // Write port straight from the accepted item
  assign in_range    = 32'(s_axis_tdata_i[lpli_pkg::F_IDX_LSB +: lpli_pkg::IDX_IN_W])
                       < MAX_POINTS;
  assign mem_we_o    = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == lpli_pkg::ACT_WRITE)
                       && in_range;
  assign mem_waddr_o = ADDR_W'(s_axis_tdata_i[lpli_pkg::F_IDX_LSB +: lpli_pkg::IDX_IN_W]);
  assign mem_wdata_o.x = s_axis_tdata_i[lpli_pkg::F_EX_LSB +: DW];
  assign mem_wdata_o.y = s_axis_tdata_i[lpli_pkg::F_EY_LSB +: DW];

  // Query against the entry just read
  assign q_below = $signed(qx_q) < $signed(mem_rdata_i.x);
  assign q_above = $signed(qx_q) > $signed(mem_rdata_i.x);
  assign q_le    = !q_above;

  // Segment ends; the held entry is always the anchor
  assign seg_a  = (state_q == lpli_pkg::S_EXT_HI) ? mem_rdata_i : lo_q;
  assign seg_b  = (state_q == lpli_pkg::S_EXT_HI) ? lo_q : mem_rdata_i;
  assign seg_dx = {seg_b.x[DW-1], seg_b.x} - {seg_a.x[DW-1], seg_a.x};
  assign seg_dy = {seg_b.y[DW-1], seg_b.y} - {seg_a.y[DW-1], seg_a.y};
  assign seg_t  = {qx_q[DW-1], qx_q} - {lo_q.x[DW-1], lo_q.x};

  // Magnitudes for the unsigned product and divide
  assign dx_abs = dx_q[XW-1] ? (~dx_q + XW'(1)) : dx_q;
  assign dy_abs = dy_q[XW-1] ? (~dy_q + XW'(1)) : dy_q;
  assign t_abs  = t_q[XW-1]  ? (~t_q + XW'(1))  : t_q;

  // Apply the signed quotient to the anchor y
  assign y0_ext  = {{(SW-DW){y0_q[DW-1]}}, y0_q};
  assign q_ext   = {{(SW-lpli_pkg::QUO_W){1'b0}}, div_rsp_i.quo};
  assign sum     = neg_q ? (y0_ext - q_ext) : (y0_ext + q_ext);
  assign sum_ovf = (sum[SW-1:DW-1] != '0) && (sum[SW-1:DW-1] != '1);

  assign div_req_o.start = (state_q == lpli_pkg::S_DIVGO);
  assign div_req_o.num   = prod_q;
  assign div_req_o.den   = dmag_q;

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    qx_d        = qx_q;
    lo_d        = lo_q;
    idx_d       = idx_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    t_d         = t_q;
    y0_d        = y0_q;
    prod_d      = prod_q;
    dmag_d      = dmag_q;
    neg_d       = neg_q;
    res_y_d     = res_y_q;
    res_sat_d   = res_sat_q;
    out_valid_d = out_valid_q;
    out_y_d     = out_y_q;
    out_sat_d   = out_sat_q;
    mem_raddr_o = '0;
    seg_load    = 1'b0;

    // Drop the result once transferred
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      lpli_pkg::S_IDLE: begin
        if (s_axis_tvalid_i && (s_axis_tuser_i == lpli_pkg::ACT_LOOKUP)) begin
          qx_d = s_axis_tdata_i[lpli_pkg::F_QX_LSB +: DW];
          if (few_points) begin
            res_y_d   = '0;
            res_sat_d = 1'b0;
            state_d   = lpli_pkg::S_DONE;
          end else begin
            mem_raddr_o = '0;
            state_d     = lpli_pkg::S_FIRST;
          end
        end
      end
      lpli_pkg::S_FIRST: begin
        lo_d = mem_rdata_i;
        if (q_below) begin
          case (cfg_i.extrap_mode)
            lpli_pkg::EXTRAP_CLAMP: begin
              res_y_d   = mem_rdata_i.y;
              res_sat_d = 1'b0;
              state_d   = lpli_pkg::S_DONE;
            end
            lpli_pkg::EXTRAP_LINEAR: begin
              mem_raddr_o = ADDR_W'(1);
              state_d     = lpli_pkg::S_EXT_LO;
            end
            default: begin
              res_y_d   = '0;
              res_sat_d = 1'b0;
              state_d   = lpli_pkg::S_DONE;
            end
          endcase
        end else begin
          mem_raddr_o = last_idx;
          state_d     = lpli_pkg::S_LAST;
        end
      end
      lpli_pkg::S_EXT_LO: begin
        seg_load = 1'b1;
        state_d  = lpli_pkg::S_MUL;
      end
      lpli_pkg::S_LAST: begin
        if (q_above) begin
          case (cfg_i.extrap_mode)
            lpli_pkg::EXTRAP_CLAMP: begin
              res_y_d   = mem_rdata_i.y;
              res_sat_d = 1'b0;
              state_d   = lpli_pkg::S_DONE;
            end
            lpli_pkg::EXTRAP_LINEAR: begin
              lo_d        = mem_rdata_i;
              mem_raddr_o = last_idx - ADDR_W'(1);
              state_d     = lpli_pkg::S_EXT_HI;
            end
            default: begin
              res_y_d   = '0;
              res_sat_d = 1'b0;
              state_d   = lpli_pkg::S_DONE;
            end
          endcase
        end else if (cfg_i.interp_mode != lpli_pkg::INTERP_LINEAR) begin
          res_y_d   = '0;
          res_sat_d = 1'b0;
          state_d   = lpli_pkg::S_DONE;
        end else begin
          idx_d       = ADDR_W'(1);
          mem_raddr_o = ADDR_W'(1);
          state_d     = lpli_pkg::S_SCAN;
        end
      end
      lpli_pkg::S_EXT_HI: begin
        seg_load = 1'b1;
        state_d  = lpli_pkg::S_MUL;
      end
      lpli_pkg::S_SCAN: begin
        // Advance until the upper breakpoint reaches the query or the last entry
        if (q_le || (idx_q == last_idx)) begin
          seg_load = 1'b1;
          state_d  = lpli_pkg::S_MUL;
        end else begin
          lo_d        = mem_rdata_i;
          idx_d       = idx_q + ADDR_W'(1);
          mem_raddr_o = idx_q + ADDR_W'(1);
        end
      end
      lpli_pkg::S_MUL: begin
        if (dx_q == '0) begin
          res_y_d   = y0_q;
          res_sat_d = 1'b0;
          state_d   = lpli_pkg::S_DONE;
        end else begin
          prod_d  = dy_abs[DW-1:0] * t_abs[DW-1:0];
          dmag_d  = dx_abs[DW-1:0];
          neg_d   = dy_q[XW-1] ^ t_q[XW-1] ^ dx_q[XW-1];
          state_d = lpli_pkg::S_DIVGO;
        end
      end
      lpli_pkg::S_DIVGO: begin
        state_d = lpli_pkg::S_DIV;
      end
      lpli_pkg::S_DIV: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.big) begin
            res_y_d   = neg_q ? lpli_pkg::Y_MIN : lpli_pkg::Y_MAX;
            res_sat_d = 1'b1;
          end else if (sum_ovf) begin
            res_y_d   = sum[SW-1] ? lpli_pkg::Y_MIN : lpli_pkg::Y_MAX;
            res_sat_d = 1'b1;
          end else begin
            res_y_d   = sum[DW-1:0];
            res_sat_d = 1'b0;
          end
          state_d = lpli_pkg::S_DONE;
        end
      end
      lpli_pkg::S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_y_d     = res_y_q;
          out_sat_d   = res_sat_q;
          state_d     = lpli_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lpli_pkg::S_IDLE;
      end
    endcase

    // Capture the segment differences and the anchor
    if (seg_load) begin
      dx_d = seg_dx;
      dy_d = seg_dy;
      t_d  = seg_t;
      y0_d = lo_q.y;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpli_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    qx_q      <= qx_d;
    lo_q      <= lo_d;
    idx_q     <= idx_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    t_q       <= t_d;
    y0_q      <= y0_d;
    prod_q    <= prod_d;
    dmag_q    <= dmag_d;
    neg_q     <= neg_d;
    res_y_q   <= res_y_d;
    res_sat_q <= res_sat_d;
    out_y_q   <= out_y_d;
    out_sat_q <= out_sat_d;
  end

  assign s_axis_tready_o = (state_q == lpli_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_y_q;
  assign m_axis_tuser_o  = out_sat_q;

  `LPLI_ASSERT_HOLD(a_sat_at_limit, clk_i, rst_ni, out_valid_q && out_sat_q, (out_y_q == lpli_pkg::Y_MAX) || (out_y_q == lpli_pkg::Y_MIN), "saturated result not at a limit")
  `LPLI_ASSERT_NEXT(a_div_done_finish, clk_i, rst_ni, (state_q == lpli_pkg::S_DIV) && div_rsp_i.done, state_q == lpli_pkg::S_DONE, "divide result not taken")
  `LPLI_ASSERT_HOLD(a_div_start_idle, clk_i, rst_ni, div_req_o.start, !div_rsp_i.busy, "divider started while busy")

endmodule
